// File: sv/magnet_occupancy_detector_core_defines.svh
// Assertion macros for the magnet occupancy detector checker.
// Depends on a clk and an rst signal in the scope that uses them.
`ifndef MAGNET_OCCUPANCY_DETECTOR_CORE_DEFINES_SVH
`define MAGNET_OCCUPANCY_DETECTOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MOCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MOCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/mocd_pkg.sv
// Shared types and constants of the magnet occupancy detector.
// Used by the axis lanes, the merge stage and the top level.
package mocd_pkg;

  localparam int AXIS_W   = 16;
  localparam int NUM_AXES = 3;
  localparam int COUNT_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STABLE_DELTA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_DELTA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED = 2'd2;

  localparam logic [AXIS_W-1:0]  STABLE_DELTA_RST  = 16'd10;
  localparam logic [AXIS_W-1:0]  PRESENT_DELTA_RST = 16'd250;
  localparam logic [COUNT_W-1:0] STABLE_NEEDED_RST = 4'd5;

  typedef logic [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic stable;
    logic present;
  } lane_flags_t;

  typedef struct packed {
    logic calibrated;
    logic magnet_present;
    logic occupied;
  } result_t;

endpackage

// File: sv/mocd_lane.sv
// One axis lane: absolute deviation of a sample from the baseline and
// its compares against the two thresholds. Depends on mocd_pkg.
module mocd_lane (
  input  logic signed [mocd_pkg::AXIS_W-1:0] sample,
  input  mocd_pkg::axis_t                    base,
  input  mocd_pkg::axis_t                    stable_delta,
  input  mocd_pkg::axis_t                    present_delta,
  output mocd_pkg::lane_flags_t              flags
);

  logic signed [mocd_pkg::AXIS_W:0] diff;
  logic [mocd_pkg::AXIS_W:0]        mag;
  mocd_pkg::axis_t                  dev;

  // The magnitude never exceeds 65535, so the top bit of mag is dropped.
  assign diff = $signed({base[mocd_pkg::AXIS_W-1], base}) -
                $signed({sample[mocd_pkg::AXIS_W-1], sample});
  assign mag  = diff[mocd_pkg::AXIS_W] ? -diff : diff;
  assign dev  = mag[mocd_pkg::AXIS_W-1:0];

  assign flags.stable  = dev < stable_delta;
  assign flags.present = dev > present_delta;

endmodule

// File: sv/mocd_merge.sv
// Merge stage: combines the lane flags, holds the baseline, calibration
// and occupancy state, and forms the result word. Depends on mocd_pkg.
module mocd_merge (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            accept,
  input  logic                                            button,
  input  mocd_pkg::axis_t [mocd_pkg::NUM_AXES-1:0]        sample,
  input  mocd_pkg::lane_flags_t [mocd_pkg::NUM_AXES-1:0]  flags,
  input  logic [mocd_pkg::COUNT_W-1:0]                    stable_needed,
  output mocd_pkg::axis_t [mocd_pkg::NUM_AXES-1:0]        base,
  output mocd_pkg::result_t                               result
);

  logic                                     base_valid;
  logic [mocd_pkg::COUNT_W-1:0]             stable_count;
  logic                                     is_calibrated;
  logic                                     last_present;
  logic                                     occupancy;

  mocd_pkg::axis_t [mocd_pkg::NUM_AXES-1:0] base_next;
  logic                                     base_valid_next;
  logic [mocd_pkg::COUNT_W-1:0]             stable_count_next;
  logic [mocd_pkg::COUNT_W-1:0]             count_inc;
  logic                                     is_calibrated_next;
  logic                                     last_present_next;
  logic                                     occupancy_next;
  logic                                     present;
  logic                                     all_stable;
  logic                                     any_present;

  always_comb begin
    all_stable  = 1'b1;
    any_present = 1'b0;
    for (int i = 0; i < mocd_pkg::NUM_AXES; i++) begin
      all_stable  = all_stable & flags[i].stable;
      any_present = any_present | flags[i].present;
    end
  end

  assign count_inc = stable_count + 1'b1;

  always_comb begin
    base_next          = base;
    base_valid_next    = base_valid;
    stable_count_next  = stable_count;
    is_calibrated_next = is_calibrated;
    last_present_next  = last_present;
    occupancy_next     = occupancy;
    present            = 1'b0;
    if (button) begin
      occupancy_next = ~occupancy;
      present        = last_present;
    end else if (is_calibrated) begin
      present           = any_present;
      last_present_next = any_present;
      if (any_present && !last_present) begin
        occupancy_next = ~occupancy;
      end
    end else if (!base_valid) begin
      base_next         = sample;
      base_valid_next   = 1'b1;
      stable_count_next = '0;
    end else if (all_stable) begin
      stable_count_next = count_inc;
      if (count_inc >= stable_needed) begin
        is_calibrated_next = 1'b1;
      end
    end else begin
      stable_count_next = '0;
      base_next         = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base          <= '0;
      base_valid    <= 1'b0;
      stable_count  <= '0;
      is_calibrated <= 1'b0;
      last_present  <= 1'b0;
      occupancy     <= 1'b0;
    end else if (accept) begin
      base          <= base_next;
      base_valid    <= base_valid_next;
      stable_count  <= stable_count_next;
      is_calibrated <= is_calibrated_next;
      last_present  <= last_present_next;
      occupancy     <= occupancy_next;
    end
  end

  assign result.occupied       = occupancy_next;
  assign result.magnet_present = present;
  assign result.calibrated     = is_calibrated_next;

endmodule

// File: sv/magnet_occupancy_detector_core.sv
// Top level of the magnet occupancy detector: stream ports, configuration
// registers, three axis lanes, the merge stage and the output register.
// Depends on mocd_pkg, mocd_lane and mocd_merge.
//
// The block takes one word per clock cycle while its output is not stalled
// and returns one result word for each, in the cycle after it is accepted.
// The three axis lanes compute their deviations side by side, and the merge
// stage updates the baseline and occupancy state in the same cycle, so that
// state loop sets the rate. A result word waits in the output register while
// the next input word is accepted in the same cycle it is taken downstream.
module magnet_occupancy_detector_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [47:0]                        s_axis_tdata,  // axis_x, axis_y, axis_z
  input  logic                               s_axis_tuser,  // opcode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // occupied, magnet_present,
                                                            // calibrated, zero pad
  input  logic                               cfg_we,
  input  logic [mocd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mocd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                                           accept;
  mocd_pkg::axis_t                                stable_delta;
  mocd_pkg::axis_t                                present_delta;
  logic [mocd_pkg::COUNT_W-1:0]                   stable_needed;
  mocd_pkg::axis_t [mocd_pkg::NUM_AXES-1:0]       sample;
  mocd_pkg::axis_t [mocd_pkg::NUM_AXES-1:0]       base;
  mocd_pkg::lane_flags_t [mocd_pkg::NUM_AXES-1:0] flags;
  mocd_pkg::result_t                              result;
  mocd_pkg::result_t                              out_result;
  logic                                           out_valid;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sample        = s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_delta  <= mocd_pkg::STABLE_DELTA_RST;
      present_delta <= mocd_pkg::PRESENT_DELTA_RST;
      stable_needed <= mocd_pkg::STABLE_NEEDED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mocd_pkg::REG_STABLE_DELTA: begin
          stable_delta <= cfg_wdata;
        end
        mocd_pkg::REG_PRESENT_DELTA: begin
          present_delta <= cfg_wdata;
        end
        mocd_pkg::REG_STABLE_NEEDED: begin
          stable_needed <= cfg_wdata[mocd_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < mocd_pkg::NUM_AXES; i++) begin : g_lane
    mocd_lane u_lane (
      .sample        ($signed(sample[i])),
      .base          (base[i]),
      .stable_delta  (stable_delta),
      .present_delta (present_delta),
      .flags         (flags[i])
    );
  end

  mocd_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .button        (s_axis_tuser),
    .sample        (sample),
    .flags         (flags),
    .stable_needed (stable_needed),
    .base          (base),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_result};

endmodule

// File: sv/mocd_checker.sv
// Port-level checker for magnet_occupancy_detector_core, bound to it below.
// Depends on the assertion macros in magnet_occupancy_detector_core_defines.svh.
`include "magnet_occupancy_detector_core_defines.svh"

module mocd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [7:0]                      m_axis_tdata
);

  `MOCD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `MOCD_ASSERT_NEXT(a_word_out, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
  `MOCD_ASSERT_SAME(a_ready_free, !m_axis_tvalid, s_axis_tready)
  `MOCD_ASSERT_SAME(a_present_cal, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[2])

endmodule

bind magnet_occupancy_detector_core mocd_checker u_mocd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
